// ----- rtl/lsb123_pkg.sv -----
// shared types and constants for the rgb 1-2-3 low-bit embed / extract block
// no dependencies; imported by every module under rtl

package lsb123_pkg;

   // operating mode held in the one control register
   typedef enum logic {
      MODE_EMBED   = 1'b0,
      MODE_EXTRACT = 1'b1
   } mode_type;

   // what an input item carries
   typedef enum logic {
      KIND_MESSAGE = 1'b0,
      KIND_CARRIER = 1'b1
   } kind_type;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // end marker characters
   localparam logic [7:0] MARK_EQ    = 8'h3D; // =
   localparam logic [7:0] MARK_LT    = 8'h3C; // <
   localparam logic [7:0] MARK_E     = 8'h45; // E
   localparam logic [7:0] MARK_N     = 8'h4E; // N
   localparam logic [7:0] MARK_D     = 8'h44; // D
   localparam logic [7:0] MARK_BANG  = 8'h21; // !
   localparam logic [7:0] MARK_GT    = 8'h3E; // >

   // classified item travelling from front to back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } item_type;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_message;
      logic       wants_message;
      logic       end_found;
   } result_type;

   // back-end status seen by the top level
   typedef struct packed {
      logic [3:0] bit_count;
      logic       finished;
   } back_status_type;

endpackage

// ----- rtl/lsb123_front.sv -----
// front end: accepts request transfers and classifies them into queue items
// depends on lsb123_pkg; feeds lsb123_queue

module lsb123_front (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  lsb123_pkg::mode_type  mode,
   input  logic                  queue_full,
   output logic                  push,
   output lsb123_pkg::item_type  push_item
);
   import lsb123_pkg::*;

   logic accept;
   logic keep;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // message bytes mean nothing while extracting, so they are dropped here
   always_comb begin
      keep = 1'b1;
      if (kind_type'(req_tuser) == KIND_MESSAGE && mode == MODE_EXTRACT) begin
         keep = 1'b0;
      end
   end

   assign push           = accept && keep;
   assign push_item.kind = kind_type'(req_tuser);
   assign push_item.data = req_tdata;
   assign push_item.last = req_tlast;

endmodule

// ----- rtl/lsb123_queue.sv -----
// two-entry item queue between front and back ends
// depends on lsb123_pkg for the item type

module lsb123_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lsb123_pkg::item_type  push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output lsb123_pkg::item_type  head_item
);
   import lsb123_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/lsb123_back.sv -----
// back end: bit buffer, channel phase, marker tracking and the result register
// depends on lsb123_pkg; pops items from lsb123_queue

module lsb123_back #(
   parameter int END_RUN = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  lsb123_pkg::mode_type        mode,
   input  logic                        head_valid,
   input  lsb123_pkg::item_type        head_item,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lsb123_pkg::result_type      rsp,
   output lsb123_pkg::back_status_type status
);
   import lsb123_pkg::*;

   logic [9:0] bit_buffer_ff,   bit_buffer_in;
   logic [3:0] bit_count_ff,    bit_count_in;
   logic [1:0] phase_ff,        phase_in;
   logic       message_over_ff, message_over_in;
   logic [3:0] marker_run_ff,   marker_run_in;
   logic       finished_ff,     finished_in;
   logic       rsp_valid_ff,    rsp_valid_in;
   result_type rsp_ff,          rsp_in;

   logic       res_valid;
   result_type res;

   function automatic logic [1:0] bits_for_phase(input logic [1:0] phase);
      logic [1:0] n;
      case (phase)
         2'd0:    n = 2'd1;
         2'd1:    n = 2'd2;
         default: n = 2'd3;
      endcase
      return n;
   endfunction

   function automatic logic [9:0] low_mask(input logic [3:0] cnt);
      logic [9:0] m;
      for (int i = 0; i < 10; i++) begin
         m[i] = (4'(i) < cnt);
      end
      return m;
   endfunction

   function automatic logic is_marker(input logic [7:0] b);
      return b == MARK_EQ || b == MARK_LT || b == MARK_E || b == MARK_N ||
             b == MARK_D || b == MARK_BANG || b == MARK_GT;
   endfunction

   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      logic [9:0] buf_v;
      logic [3:0] cnt_v;
      logic [3:0] idx_v;
      logic [7:0] byte_v;
      logic [9:0] shifted_v;
      logic [1:0] need_v;
      logic [1:0] phase_next_v;
      logic       fin_v;
      logic [3:0] run_v;

      bit_buffer_in   = bit_buffer_ff;
      bit_count_in    = bit_count_ff;
      phase_in        = phase_ff;
      message_over_in = message_over_ff;
      marker_run_in   = marker_run_ff;
      finished_in     = finished_ff;
      res_valid       = 1'b0;
      res             = '0;

      buf_v        = bit_buffer_ff;
      cnt_v        = bit_count_ff;
      byte_v       = head_item.data;
      idx_v        = '0;
      shifted_v    = '0;
      fin_v        = finished_ff;
      run_v        = marker_run_ff;
      need_v       = bits_for_phase(phase_ff);
      phase_next_v = (phase_ff >= 2'd2) ? 2'd0 : phase_ff + 2'd1;

      if (pop) begin
         if (head_item.kind == KIND_MESSAGE) begin
            // load only while there is room and the message is still open
            if (mode == MODE_EMBED && !message_over_ff && bit_count_ff <= 4'd2) begin
               bit_buffer_in = {bit_buffer_ff[1:0], head_item.data};
               bit_count_in  = bit_count_ff + 4'd8;
               if (head_item.last) begin
                  message_over_in = 1'b1;
               end
            end
         end else if (mode == MODE_EMBED) begin
            // oldest buffered bit goes to bit 0, up to three bits
            for (int j = 0; j < 3; j++) begin
               if (2'(j) < need_v && cnt_v != 4'd0) begin
                  idx_v     = cnt_v - 4'd1;
                  byte_v[j] = buf_v[idx_v];
                  cnt_v     = cnt_v - 4'd1;
               end
            end
            fin_v           = finished_ff | (message_over_ff & (cnt_v == 4'd0));
            bit_buffer_in   = buf_v & low_mask(cnt_v);
            bit_count_in    = cnt_v;
            phase_in        = phase_next_v;
            finished_in     = fin_v;
            res_valid       = 1'b1;
            res.out_byte    = byte_v;
            res.is_message  = 1'b0;
            res.wants_message = !message_over_ff &&
                                (cnt_v < {2'b00, bits_for_phase(phase_next_v)});
            res.end_found   = fin_v;
         end else begin
            phase_in = phase_next_v;
            if (!finished_ff) begin
               for (int j = 0; j < 3; j++) begin
                  if (2'(j) < need_v) begin
                     buf_v = {buf_v[8:0], head_item.data[j]};
                     cnt_v = cnt_v + 4'd1;
                  end
               end
               if (cnt_v >= 4'd8) begin
                  shifted_v = buf_v >> (cnt_v - 4'd8);
                  byte_v    = shifted_v[7:0];
                  cnt_v     = cnt_v - 4'd8;
                  buf_v     = buf_v & low_mask(cnt_v);
                  if (is_marker(byte_v)) begin
                     if (run_v != 4'd15) begin
                        run_v = run_v + 4'd1;
                     end
                  end else begin
                     run_v = 4'd0;
                  end
                  fin_v             = (run_v >= 4'(END_RUN));
                  res_valid         = 1'b1;
                  res.out_byte      = byte_v;
                  res.is_message    = 1'b1;
                  res.wants_message = 1'b0;
                  res.end_found     = fin_v;
               end
               bit_buffer_in = buf_v;
               bit_count_in  = cnt_v;
               marker_run_in = run_v;
               finished_in   = fin_v;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (pop && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         bit_buffer_ff   <= '0;
         bit_count_ff    <= '0;
         phase_ff        <= '0;
         message_over_ff <= 1'b0;
         marker_run_ff   <= '0;
         finished_ff     <= 1'b0;
      end else begin
         bit_buffer_ff   <= bit_buffer_in;
         bit_count_ff    <= bit_count_in;
         phase_ff        <= phase_in;
         message_over_ff <= message_over_in;
         marker_run_ff   <= marker_run_in;
         finished_ff     <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp              = rsp_ff;
   assign status.bit_count = bit_count_ff;
   assign status.finished  = finished_ff;

endmodule

// ----- rtl/lsb_123_stego_embed_extract.sv -----
// top level of the rgb 1-2-3 low-bit embed / extract block
// depends on lsb123_pkg, lsb123_front, lsb123_queue and lsb123_back
//
//   channel  | direction | accepted when           | contents
//   ---------+-----------+-------------------------+----------------------------------
//   req_*    | in        | req_tvalid & req_tready | tdata in_byte, tuser action,
//            |           |                         | tlast last_message_byte
//   rsp_*    | out       | rsp_tvalid & rsp_tready | tdata out_byte, wants_message,
//            |           |                         | tuser is_message, tlast end_found
//   csr_*    | in        | csr_wen                 | csr_wdata mode (0 embed, 1 extract)
//
// one item per cycle sustained while rsp_tready stays high; a carrier result passes
// from its request transfer into the item queue and then into the result register
// reset is synchronous and active high; mode goes to embed and the queue, back-end
// state and result valid clear; a csr write clears only the back-end state as it loads
// the new mode; the two-entry queue lets the front keep taking items while the result
// register waits on rsp_tready; req_tready drops only when the queue is full

module lsb_123_stego_embed_extract #(
   parameter int END_RUN = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [lsb123_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] action: 0 message byte, 1 carrier byte
   input  logic        req_tlast,   // last_message_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte, [8] wants_message, [15:9] zero
   output logic [lsb123_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] is_message
   output logic        rsp_tlast,   // end_found
   // control register
   input  logic        csr_wen,
   input  logic        csr_wdata    // mode
);
   import lsb123_pkg::*;

   mode_type        mode_ff, mode_in;
   logic            push;
   item_type        push_item;
   logic            queue_full;
   logic            pop;
   logic            head_valid;
   item_type        head_item;
   result_type      rsp;
   back_status_type status;

   // mode register; the user writes it only while the block is idle (not enforced)
   assign mode_in = csr_wen ? mode_type'(csr_wdata) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_EMBED;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // front: takes transfers and drops message bytes while extracting
   lsb123_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .mode       (mode_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // short queue decoupling the two halves
   lsb123_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // back: bit buffer update, marker run and the result register
   lsb123_back #(
      .END_RUN (END_RUN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clear      (csr_wen),
      .mode       (mode_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp),
      .status     (status)
   );

   // pack the result fields onto the stream
   assign rsp_tdata = {7'b0000000, rsp.wants_message, rsp.out_byte};
   assign rsp_tuser = rsp.is_message;
   assign rsp_tlast = rsp.end_found;

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && queue_full))
      else $error("item pushed into full queue");

   // the bit buffer never holds more than ten bits
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      status.bit_count <= 4'd10)
      else $error("bit count out of range");

   // an extracted byte never asks for a message byte
   a_extract_no_want: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[8])
      else $error("extract result asks for message");

   // the finished flag stays set once the block has finished, until a clear
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      status.finished && !csr_wen |=> status.finished)
      else $error("finished flag dropped without clear");

endmodule
